### design/pbpc_pkg.sv
// Shared constants and register indexes for the power button press classifier.
`timescale 1ns / 1ps

package pbpc_pkg;

  // Counter and threshold width
  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] CntMax = '1;

  // Configuration port shape
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = CntW;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_LOW      = 3'd0,
    REG_POWER_DOWN_TIME = 3'd1,
    REG_FORCE_ON_TIME   = 3'd2,
    REG_PRESSED_TIME    = 3'd3,
    REG_RELEASE_TIME    = 3'd4
  } cfg_reg_t;

  // Register reset values
  localparam logic            ActiveLowRst     = 1'b1;
  localparam logic [CntW-1:0] PowerDownTimeRst = 16'd3000;
  localparam logic [CntW-1:0] ForceOnTimeRst   = 16'd5000;
  localparam logic [CntW-1:0] PressedTimeRst   = 16'd1000;
  localparam logic [CntW-1:0] ReleaseTimeRst   = 16'd500;

  // Saturating increment of a tick counter
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? CntMax : v + 1'b1;
  endfunction

endpackage

### design/power_button_press_classifier_core.sv
// Top level of the power button press classifier.
`timescale 1ns / 1ps

// Power button press classifier.
// Input channel (in_valid / in_stall / in_button_level) takes one button sample per
// millisecond tick. Result channel (out_valid / out_stall / out_*) gives one result
// per sample: the pressed flag, the sticky power-down request, the press state
// latched at start-up and a single-tick force-on pulse.
// The first sample after reset only latches the start-up press state.
// A sample's result shows in the cycle after its transfer. Throughput is one
// sample per cycle while the receiver does not stall; the hold and release
// counters and their threshold compares all settle combinationally, into the result register.
// The result register parts the channels: a new sample is taken while the
// current result waits, as long as that result is transferred in the same
// cycle; while the receiver stalls a waiting result, in_stall is high and the
// result holds.
// Reset (rst_n low, synchronous) clears all tracking state, drops out_valid
// and loads the registers with their defaults. The cfg_* port writes a register
// at any edge with cfg_we high; write only while no sample is in flight.
module power_button_press_classifier_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [pbpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pbpc_pkg::CfgDataW-1:0] cfg_wdata,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_button_level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_button_pressed,
  output logic                          out_power_down_request,
  output logic                          out_boot_button_pressed,
  output logic                          out_force_on_pulse
);

  localparam int unsigned CntW = pbpc_pkg::CntW;

  // Configuration registers
  logic            active_low_r;
  logic [CntW-1:0] power_down_time_r;
  logic [CntW-1:0] force_on_time_r;
  logic [CntW-1:0] pressed_time_r;
  logic [CntW-1:0] release_time_r;

  // Tracking state
  logic            started_r, started_nxt;
  logic            last_level_r, last_level_nxt;
  logic            press_from_boot_r, press_from_boot_nxt;
  logic            boot_latch_r, boot_latch_nxt;
  logic [CntW-1:0] press_count_r, press_count_nxt;
  logic [CntW-1:0] release_count_r, release_count_nxt;
  logic            pressed_flag_r, pressed_flag_nxt;
  logic            down_request_r, down_request_nxt;
  logic            force_fired_r, force_fired_nxt;
  logic            pulse_nxt;

  // Result register
  logic out_valid_r;
  logic out_pressed_r, out_down_r, out_boot_r, out_pulse_r;

  logic in_xfer, out_free, pressed, edge_press, pd_fire, fo_fire;

  // Take a sample whenever the result register is empty or drains this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !out_free;
  assign in_xfer  = in_valid && out_free;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r      <= pbpc_pkg::ActiveLowRst;
      power_down_time_r <= pbpc_pkg::PowerDownTimeRst;
      force_on_time_r   <= pbpc_pkg::ForceOnTimeRst;
      pressed_time_r    <= pbpc_pkg::PressedTimeRst;
      release_time_r    <= pbpc_pkg::ReleaseTimeRst;
    end else if (cfg_we) begin
      case (cfg_index)
        pbpc_pkg::REG_ACTIVE_LOW:      active_low_r      <= cfg_wdata[0];
        pbpc_pkg::REG_POWER_DOWN_TIME: power_down_time_r <= cfg_wdata;
        pbpc_pkg::REG_FORCE_ON_TIME:   force_on_time_r   <= cfg_wdata;
        pbpc_pkg::REG_PRESSED_TIME:    pressed_time_r    <= cfg_wdata;
        pbpc_pkg::REG_RELEASE_TIME:    release_time_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Classify one sample
  always_comb begin
    pressed    = in_button_level ^ active_low_r;
    edge_press = 1'b0;
    pd_fire    = 1'b0;
    fo_fire    = 1'b0;
    pulse_nxt  = 1'b0;

    started_nxt         = started_r;
    last_level_nxt      = last_level_r;
    press_from_boot_nxt = press_from_boot_r;
    boot_latch_nxt      = boot_latch_r;
    press_count_nxt     = press_count_r;
    release_count_nxt   = release_count_r;
    pressed_flag_nxt    = pressed_flag_r;
    down_request_nxt    = down_request_r;
    force_fired_nxt     = force_fired_r;

    if (!started_r) begin
      // latch the start-up press state only
      started_nxt         = 1'b1;
      last_level_nxt      = pressed;
      press_from_boot_nxt = pressed;
      boot_latch_nxt      = pressed;
      press_count_nxt     = '0;
      release_count_nxt   = '0;
    end else begin
      // track edges; a release ends the boot press
      edge_press     = pressed && !last_level_r;
      if (last_level_r && !pressed) begin
        press_from_boot_nxt = 1'b0;
      end
      last_level_nxt = pressed;

      if (pressed) begin
        press_count_nxt = edge_press ? '0 : pbpc_pkg::sat_inc(press_count_r);
        // a firing rule zeroes the hold time for the later rules
        pd_fire = (press_count_nxt >= power_down_time_r) && !press_from_boot_nxt;
        fo_fire = (press_count_nxt >= force_on_time_r) && press_from_boot_nxt;
        if (pd_fire) begin
          down_request_nxt = 1'b1;
        end
        if (fo_fire && !force_fired_r) begin
          force_fired_nxt = 1'b1;
          pulse_nxt       = 1'b1;
        end
        if (!pd_fire && !press_from_boot_nxt && (press_count_nxt > pressed_time_r)) begin
          pressed_flag_nxt = 1'b1;
        end
        release_count_nxt = '0;
      end else begin
        release_count_nxt = pbpc_pkg::sat_inc(release_count_r);
        if (release_count_nxt >= release_time_r) begin
          release_count_nxt = '0;
          pressed_flag_nxt  = 1'b0;
        end
      end
    end
  end

  // Advance tracking state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r         <= 1'b0;
      last_level_r      <= 1'b0;
      press_from_boot_r <= 1'b0;
      boot_latch_r      <= 1'b0;
      press_count_r     <= '0;
      release_count_r   <= '0;
      pressed_flag_r    <= 1'b0;
      down_request_r    <= 1'b0;
      force_fired_r     <= 1'b0;
    end else if (in_xfer) begin
      started_r         <= started_nxt;
      last_level_r      <= last_level_nxt;
      press_from_boot_r <= press_from_boot_nxt;
      boot_latch_r      <= boot_latch_nxt;
      press_count_r     <= press_count_nxt;
      release_count_r   <= release_count_nxt;
      pressed_flag_r    <= pressed_flag_nxt;
      down_request_r    <= down_request_nxt;
      force_fired_r     <= force_fired_nxt;
    end
  end

  // Result valid: load on input transfer, drop once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_xfer;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_pressed_r <= pressed_flag_nxt;
      out_down_r    <= down_request_nxt;
      out_boot_r    <= boot_latch_nxt;
      out_pulse_r   <= pulse_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_button_pressed      = out_pressed_r;
  assign out_power_down_request  = out_down_r;
  assign out_boot_button_pressed = out_boot_r;
  assign out_force_on_pulse      = out_pulse_r;

endmodule

### design/pbpc_checker.sv
// Port-level checker for the power button press classifier, bound to the top level.
`timescale 1ns / 1ps

module pbpc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_button_pressed,
  input logic out_power_down_request,
  input logic out_boot_button_pressed,
  input logic out_force_on_pulse
);

  // Remember a power-down request once transferred
  logic seen_down_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_down_r <= 1'b0;
    end else if (out_valid && !out_stall && out_power_down_request) begin
      seen_down_r <= 1'b1;
    end
  end

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_button_pressed) && $stable(out_power_down_request)
      && $stable(out_boot_button_pressed) && $stable(out_force_on_pulse))
    else $error("stalled result payload changed");

  // Input stalls exactly while a result waits on a stalled receiver
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow result backpressure");

  // Every input transfer yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("input transfer without result");

  // Power-down request is sticky
  a_down_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_down_r |-> out_power_down_request)
    else $error("power-down request cleared");

endmodule

bind power_button_press_classifier_core pbpc_checker u_pbpc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_stall                (in_stall),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_button_pressed      (out_button_pressed),
  .out_power_down_request  (out_power_down_request),
  .out_boot_button_pressed (out_boot_button_pressed),
  .out_force_on_pulse      (out_force_on_pulse)
);

### sim/tb_top.sv
// Self-checking testbench for the power button press classifier core.
`timescale 1ns / 1ps

module tb_top;

  // Local shapes of the package widths
  typedef logic [pbpc_pkg::CntW-1:0]     cnt_t;
  typedef logic [pbpc_pkg::CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [pbpc_pkg::CfgDataW-1:0] cfg_data_t;

  // Result flags in port order, MSB first
  typedef struct packed {
    logic button_pressed;
    logic power_down_request;
    logic boot_button_pressed;
    logic force_on_pulse;
  } flags_t;

  typedef struct packed {
    logic active_low;
    cnt_t power_down_time;
    cnt_t force_on_time;
    cnt_t pressed_time;
    cnt_t release_time;
  } thresholds_t;

  typedef struct packed {
    logic   level;
    logic   typed;
    flags_t want;
  } boot_row_t;

  // Line levels while the line is active low (the reset setting)
  localparam logic LINE_DOWN = 1'b0;
  localparam logic LINE_UP   = 1'b1;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 40;
  localparam int RAND_PHASES  = 10;
  localparam int RAND_ITEMS   = 128;
  localparam int MAX_PRINTS   = 40;

  // Boot press table: first tick, force-on firing once, boot release, new presses
  localparam boot_row_t BOOT_ROWS [14] = '{
    '{LINE_DOWN, 1'b1, 4'b0010},
    '{LINE_DOWN, 1'b1, 4'b0010},
    '{LINE_DOWN, 1'b1, 4'b0010},
    '{LINE_DOWN, 1'b1, 4'b0010},
    '{LINE_DOWN, 1'b1, 4'b0011},
    '{LINE_DOWN, 1'b1, 4'b0010},
    '{LINE_DOWN, 1'b1, 4'b0010},
    '{LINE_UP,   1'b1, 4'b0010},
    '{LINE_DOWN, 1'b0, 4'b0000},
    '{LINE_DOWN, 1'b0, 4'b0000},
    '{LINE_UP,   1'b0, 4'b0000},
    '{LINE_UP,   1'b0, 4'b0000},
    '{LINE_DOWN, 1'b0, 4'b0000},
    '{LINE_UP,   1'b0, 4'b0000}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_index;
  cfg_data_t cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_button_level;
  logic out_valid;
  logic out_stall;
  logic out_button_pressed;
  logic out_power_down_request;
  logic out_boot_button_pressed;
  logic out_force_on_pulse;

  // Predictor copy of the registers and tracking state
  thresholds_t thr;
  logic        tk_started;
  logic        tk_last;
  logic        tk_boot_hold;
  logic        tk_boot_latch;
  cnt_t        tk_press_cnt;
  cnt_t        tk_rel_cnt;
  logic        tk_pressed;
  logic        tk_down;
  logic        tk_forced;

  flags_t flags_due [$];
  string  field_name [4] = '{"force_on_pulse", "boot_button_pressed",
                             "power_down_request", "button_pressed"};

  bit send_idle;
  bit recv_idle;
  bit hold_req;
  int mismatches;
  int ticks_sent;
  int flags_checked;
  int settings_used;
  int pressed_seen;
  int down_seen;
  int pulses_seen;
  int quiet_cycles;

  power_button_press_classifier_core u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_button_level         (in_button_level),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_button_pressed      (out_button_pressed),
    .out_power_down_request  (out_power_down_request),
    .out_boot_button_pressed (out_boot_button_pressed),
    .out_force_on_pulse      (out_force_on_pulse)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH %s", msg);
  endtask

  // Count up and pin at the top of the counter range
  function automatic cnt_t bump(input cnt_t v);
    return v + {{(pbpc_pkg::CntW-1){1'b0}}, ~&v};
  endfunction

  // Advance the predicted tracking state by one tick and give its flags
  task automatic classify_tick(input logic level, output flags_t r);
    logic pr;
    logic rise;
    logic fire;
    cnt_t held;
    pr   = level ^ thr.active_low;
    fire = 1'b0;
    if (!tk_started) begin
      // first tick only latches the start-up press state
      tk_started    = 1'b1;
      tk_last       = pr;
      tk_boot_hold  = pr;
      tk_boot_latch = pr;
      tk_press_cnt  = '0;
      tk_rel_cnt    = '0;
    end else begin
      rise = 1'b0;
      if (tk_last != pr) begin
        if (tk_last) tk_boot_hold = 1'b0;
        else rise = 1'b1;
        tk_last = pr;
      end
      if (pr) begin
        tk_press_cnt = rise ? '0 : bump(tk_press_cnt);
        held = tk_press_cnt;
        // a firing power-down or force-on rule zeroes the hold for the rest of the tick
        if (held >= thr.power_down_time && !tk_boot_hold) begin
          tk_down = 1'b1;
          held = '0;
        end
        if (held >= thr.force_on_time && tk_boot_hold) begin
          if (!tk_forced) begin
            tk_forced = 1'b1;
            fire = 1'b1;
          end
          held = '0;
        end
        if (held > thr.pressed_time && !tk_boot_hold) tk_pressed = 1'b1;
        tk_rel_cnt = '0;
      end else begin
        tk_rel_cnt = bump(tk_rel_cnt);
        if (tk_rel_cnt >= thr.release_time) begin
          tk_rel_cnt = '0;
          tk_pressed = 1'b0;
        end
      end
    end
    r = {tk_pressed, tk_down, tk_boot_latch, fire};
  endtask

  // Write one register; the caller drops cfg_we after the last write
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      pbpc_pkg::REG_ACTIVE_LOW:      thr.active_low      = data[0];
      pbpc_pkg::REG_POWER_DOWN_TIME: thr.power_down_time = data;
      pbpc_pkg::REG_FORCE_ON_TIME:   thr.force_on_time   = data;
      pbpc_pkg::REG_PRESSED_TIME:    thr.pressed_time    = data;
      pbpc_pkg::REG_RELEASE_TIME:    thr.release_time    = data;
      default: ;
    endcase
  endtask

  // Write an index past the register list; the block must ignore it
  task automatic write_junk();
    cfg_idx_t bad_idx;
    bad_idx = cfg_idx_t'($urandom_range(2**pbpc_pkg::CfgIdxW - 1,
                                        int'(pbpc_pkg::REG_RELEASE_TIME) + 1));
    write_reg(bad_idx, cfg_data_t'($urandom_range(16'hFFFF, 0)));
  endtask

  task automatic program_regs(input logic al, input cnt_t pd, fo, pt, rt);
    cfg_data_t al_word;
    // junk in the upper bits of the one-bit register
    al_word    = cfg_data_t'($urandom_range(16'hFFFF, 0));
    al_word[0] = al;
    write_reg(pbpc_pkg::REG_ACTIVE_LOW, al_word);
    write_reg(pbpc_pkg::REG_POWER_DOWN_TIME, pd);
    write_reg(pbpc_pkg::REG_FORCE_ON_TIME, fo);
    write_reg(pbpc_pkg::REG_PRESSED_TIME, pt);
    write_reg(pbpc_pkg::REG_RELEASE_TIME, rt);
    write_junk();
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic cnt_t pick_threshold();
    if ($urandom_range(3, 0) == 0) return cnt_t'($urandom_range(16'hFFFF, 0));
    return cnt_t'($urandom_range(12, 0));
  endfunction

  // Offer one sample after a random gap, hold it until the transfer
  task automatic send_tick(input logic level, input logic typed, input flags_t want);
    int     gap;
    flags_t pred;
    gap = send_idle ? $urandom_range(8, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_button_level <= level;
    do @(posedge clk); while (in_stall);
    classify_tick(level, pred);
    flags_due.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  // Stop offering and let every pending result drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Receiver: random stall before each result, one long hold-off on request
  initial begin : receiver
    int w;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        w = recv_idle ? $urandom_range(8, 0) : 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each result transfer with the oldest pending prediction
  always @(posedge clk) begin : check_results
    flags_t got;
    flags_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_button_pressed, out_power_down_request,
             out_boot_button_pressed, out_force_on_pulse};
      if (flags_due.size() == 0) begin
        report($sformatf("result %0d arrived with no sample pending", flags_checked));
      end else begin
        want = flags_due.pop_front();
        for (int b = 3; b >= 0; b--) begin
          if (got[b] !== want[b])
            report($sformatf("result %0d: %s got %b want %b",
                             flags_checked, field_name[b], got[b], want[b]));
        end
      end
      flags_checked++;
      pressed_seen += got.button_pressed;
      down_seen    += got.power_down_request;
      pulses_seen  += got.force_on_pulse;
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int   left;
    int   run;
    logic held;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_button_level = 1'b0;
    out_stall       = 1'b0;
    send_idle       = 1'b1;
    recv_idle       = 1'b1;
    hold_req        = 1'b0;
    thr = {pbpc_pkg::ActiveLowRst, pbpc_pkg::PowerDownTimeRst, pbpc_pkg::ForceOnTimeRst,
           pbpc_pkg::PressedTimeRst, pbpc_pkg::ReleaseTimeRst};
    {tk_started, tk_last, tk_boot_hold, tk_boot_latch, tk_pressed, tk_down, tk_forced} = '0;
    tk_press_cnt = '0;
    tk_rel_cnt   = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short force-on time for the boot press; other registers keep reset values
    write_reg(pbpc_pkg::REG_FORCE_ON_TIME, 16'd4);
    write_junk();
    cfg_we <= 1'b0;
    settings_used++;
    for (int i = 0; i < $size(BOOT_ROWS); i++)
      send_tick(BOOT_ROWS[i].level, BOOT_ROWS[i].typed, BOOT_ROWS[i].want);
    wait_idle();

    // Settings phases: fixed corners first, then random thresholds
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: program_regs(1'b0, '0, '0, '0, '0);
        1: program_regs(1'b1, 16'd3, 16'd0, 16'd2, 16'd2);
        2: program_regs(1'b0, 16'd6, 16'd1, 16'd2, 16'd0);
        3: program_regs(1'b1, pbpc_pkg::CntMax, pbpc_pkg::CntMax, pbpc_pkg::CntMax,
                        pbpc_pkg::CntMax);
        default: program_regs(1'($urandom_range(1, 0)), pick_threshold(), pick_threshold(),
                              pick_threshold(), pick_threshold());
      endcase
      send_idle = ($urandom_range(3, 0) != 0);
      recv_idle = ($urandom_range(3, 0) != 0);
      if (p == 5) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end
      if (p == 4) begin
        // receiver holds off while the sender keeps offering back to back
        send_idle = 1'b0;
        hold_req  = 1'b1;
      end
      // runs of press and release of random length, with single-tick glitches
      left = RAND_ITEMS;
      held = 1'($urandom_range(1, 0));
      while (left > 0) begin
        run = ($urandom_range(7, 0) == 0) ? 1 : $urandom_range(24, 1);
        for (int k = 0; k < run && left > 0; k++) begin
          send_tick(held ^ thr.active_low, 1'b0, '0);
          left--;
        end
        held = ~held;
      end
      wait_idle();
    end

    $display("Run covered %0d samples under %0d register settings, %0d results checked.",
             ticks_sent, settings_used, flags_checked);
    $display("Results seen: %0d pressed, %0d power-down, %0d force-on pulse; %0d mismatches.",
             pressed_seen, down_seen, pulses_seen, mismatches);
    if (mismatches == 0 && flags_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
